// File: sv/tclp_pkg.sv
// Package for the text command line parser: types, codes and keyword tables.
// Used by every module of the parser; depends on nothing.
package tclp_pkg;

  localparam int LineBufferDef = 64;
  localparam int ValueBitsDef  = 32;
  localparam int KwCount       = 8;
  localparam int KwFreq        = 6;
  localparam int KwDuty        = 7;

  typedef enum logic [3:0] {
    PH_LEAD, PH_WORD, PH_TRAIL, PH_NUMWS, PH_SIGN, PH_ZERO, PH_X, PH_DIGITS, PH_BAD
  } phase_t;

  typedef enum logic [1:0] {ST_OK = 2'd0, ST_SYNTAX = 2'd1, ST_RANGE = 2'd2} status_t;

  typedef enum logic [2:0] {
    OPC_NONE = 3'd0, OPC_STATUS = 3'd1, OPC_ON = 3'd2, OPC_OFF = 3'd3,
    OPC_HELP = 3'd4, OPC_FREQ = 3'd5, OPC_DUTY = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {BASE_DEC = 2'd0, BASE_OCT = 2'd1, BASE_HEX = 2'd2} base_t;

  localparam logic [1:0] CfgFreqMin = 2'd0;
  localparam logic [1:0] CfgFreqMax = 2'd1;
  localparam logic [1:0] CfgDutyMax = 2'd2;

  // Keyword character at a position; zero beyond the end of the word.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [7:0] s [0:5];
    s = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    case (k)
      3'd0: s = '{"S", "T", "A", "T", "U", "S"};
      3'd1: s = '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00};
      3'd2: s = '{"S", "T", "A", "R", "T", 8'h00};
      3'd3: s = '{"O", "F", "F", 8'h00, 8'h00, 8'h00};
      3'd4: s = '{"S", "T", "O", "P", 8'h00, 8'h00};
      3'd5: s = '{"H", "E", "L", "P", 8'h00, 8'h00};
      3'd6: s = '{"F", "R", "E", "Q", 8'h00, 8'h00};
      default: s = '{"D", "U", "T", "Y", 8'h00, 8'h00};
    endcase
    return (p < 3'd6) ? s[p] : 8'h00;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0: return 3'd6;
      3'd1: return 3'd2;
      3'd2: return 3'd5;
      3'd3: return 3'd3;
      default: return 3'd4;
    endcase
  endfunction

  function automatic cmd_t kw_cmd(input logic [2:0] k);
    case (k)
      3'd0: return OPC_STATUS;
      3'd1, 3'd2: return OPC_ON;
      3'd3, 3'd4: return OPC_OFF;
      3'd5: return OPC_HELP;
      3'd6: return OPC_FREQ;
      default: return OPC_DUTY;
    endcase
  endfunction

  // Hex digit value, 16 for a non-digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd16;
  endfunction

endpackage

// File: sv/tclp_front.sv
// Front end: per-character scanner that keeps the line state and, at a line
// end, pushes a finished line summary into the queue. Depends on tclp_pkg.
module tclp_front #(
  parameter int LINE_BUFFER = tclp_pkg::LineBufferDef,
  parameter int VALUE_BITS  = tclp_pkg::ValueBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char_byte,
  output logic                  push,
  input  logic                  full,
  output tclp_pkg::phase_t      line_phase,
  output logic                  line_word_ok,
  output logic [2:0]            line_word,
  output logic                  line_overflow,
  output logic                  line_neg,
  output logic [VALUE_BITS-1:0] line_acc
);
  import tclp_pkg::*;

  localparam int CntW = $clog2(LINE_BUFFER);

  logic [CntW-1:0]       cnt_r, cnt_nxt;
  phase_t                ph_r, ph_nxt;
  logic [KwCount-1:0]    cand_r, cand_nxt;
  logic [2:0]            pos_r, pos_nxt;
  base_t                 base_r, base_nxt;
  logic                  neg_r, neg_nxt, ovf_r, ovf_nxt, pend_r, pend_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;

  logic       acc_in, eol;
  logic [7:0] c;
  logic [4:0] d;
  logic       wd_ok;
  logic [2:0] wd;
  logic [KwCount-1:0] match;
  logic [VALUE_BITS+4:0] prod;
  logic [4:0] radix;
  phase_t     ph_eff;

  assign in_stall = full;
  assign acc_in   = in_valid && !full;
  assign c        = in_char_byte;
  assign eol      = (c == 8'h00) || (c == 8'h0D) || (c == 8'h0A);
  assign d        = hex_digit(c);
  assign push     = acc_in && eol;

  // Lowest candidate whose whole word has been seen.
  always_comb begin
    wd_ok = 1'b0;
    wd    = '0;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (cand_r[k] && kw_len(3'(k)) == pos_r) begin
        wd_ok = 1'b1;
        wd    = 3'(k);
      end
    end
  end

  // Candidates that still match after this character.
  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      match[k] = cand_r[k] && (kw_len(3'(k)) > pos_r) && (kw_char(3'(k), pos_r) == c);
    end
  end

  always_comb begin
    case (base_r)
      BASE_OCT: radix = 5'd8;
      BASE_HEX: radix = 5'd16;
      default:  radix = 5'd10;
    endcase
  end
  assign prod = (VALUE_BITS+5)'(acc_r) * radix + (VALUE_BITS+5)'(d);

  // Per-character state update.
  always_comb begin
    cnt_nxt = cnt_r; ph_nxt = ph_r; cand_nxt = cand_r; pos_nxt = pos_r;
    base_nxt = base_r; neg_nxt = neg_r; ovf_nxt = ovf_r; pend_nxt = pend_r;
    acc_nxt = acc_r;
    ph_eff = ph_r;
    if (acc_in) begin
      if (eol) begin
        cnt_nxt = '0; ph_nxt = PH_LEAD; cand_nxt = '1; pos_nxt = '0;
        base_nxt = BASE_DEC; neg_nxt = 1'b0; ovf_nxt = 1'b0; pend_nxt = 1'b0;
        acc_nxt = '0;
      end else if (32'(cnt_r) < LINE_BUFFER - 1) begin
        cnt_nxt = cnt_r + 1'b1;
        if (ph_r == PH_LEAD && c != " ") begin
          ph_eff = (c == "?") ? PH_LEAD : PH_WORD;
        end
        if (ph_r == PH_NUMWS && !(c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C ||
                                  c == "+" || c == "-")) begin
          ph_eff = PH_SIGN;
        end
        case (ph_eff)
          PH_LEAD: begin
            if (c == "?") begin
              cand_nxt = 8'b1;
              ph_nxt   = PH_TRAIL;
            end
          end
          PH_WORD: begin
            if (c == " ") begin
              if (!wd_ok) ph_nxt = PH_BAD;
              else begin
                cand_nxt = 8'b1 << wd;
                ph_nxt   = (wd == 3'(KwFreq) || wd == 3'(KwDuty)) ? PH_NUMWS : PH_TRAIL;
              end
            end else if (match == '0) ph_nxt = PH_BAD;
            else begin
              cand_nxt = match;
              pos_nxt  = pos_r + 1'b1;
              ph_nxt   = PH_WORD;
            end
          end
          PH_TRAIL: if (c != " ") ph_nxt = PH_BAD;
          PH_NUMWS: begin
            if (c == "+") ph_nxt = PH_SIGN;
            else if (c == "-") begin
              neg_nxt = 1'b1;
              ph_nxt  = PH_SIGN;
            end
          end
          PH_SIGN: begin
            if (c == "0") ph_nxt = PH_ZERO;
            else if (c >= "1" && c <= "9") begin
              base_nxt = BASE_DEC; acc_nxt = VALUE_BITS'(d); ph_nxt = PH_DIGITS;
            end else ph_nxt = PH_BAD;
          end
          PH_ZERO: begin
            if (c == "x" || c == "X") ph_nxt = PH_X;
            else if (c >= "0" && c <= "7") begin
              base_nxt = BASE_OCT; acc_nxt = VALUE_BITS'(d); ph_nxt = PH_DIGITS;
            end else if (c == " ") begin
              base_nxt = BASE_OCT; acc_nxt = '0; ph_nxt = PH_DIGITS; pend_nxt = 1'b1;
            end else ph_nxt = PH_BAD;
          end
          PH_X: begin
            if (d < 5'd16) begin
              base_nxt = BASE_HEX; acc_nxt = VALUE_BITS'(d); ph_nxt = PH_DIGITS;
            end else ph_nxt = PH_BAD;
          end
          PH_DIGITS: begin
            if (c == " ") pend_nxt = 1'b1;
            else if (pend_r || d >= radix) ph_nxt = PH_BAD;
            else if (!ovf_r) begin
              if (prod[VALUE_BITS+4:VALUE_BITS] != '0) ovf_nxt = 1'b1;
              else acc_nxt = prod[VALUE_BITS-1:0];
            end
          end
          default: ph_nxt = PH_BAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ph_r <= PH_LEAD; cand_r <= '1; pos_r <= '0; base_r <= BASE_DEC;
      neg_r <= 1'b0; ovf_r <= 1'b0; pend_r <= 1'b0; acc_r <= '0;
    end else begin
      cnt_r <= cnt_nxt; ph_r <= ph_nxt; cand_r <= cand_nxt; pos_r <= pos_nxt;
      base_r <= base_nxt; neg_r <= neg_nxt; ovf_r <= ovf_nxt; pend_r <= pend_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Line summary; for trail and number phases the single candidate is the word.
  always_comb begin
    line_word_ok = wd_ok;
    line_word    = wd;
    if (ph_r != PH_WORD) begin
      line_word_ok = (cand_r != '0);
      line_word    = '0;
      for (int k = KwCount - 1; k >= 0; k--) begin
        if (cand_r[k]) line_word = 3'(k);
      end
    end
  end
  assign line_phase    = ph_r;
  assign line_overflow = ovf_r;
  assign line_neg      = neg_r;
  assign line_acc      = acc_r;
endmodule

// File: sv/tclp_back.sv
// Back end: two-entry queue of line summaries, range check and result
// register. Depends on tclp_pkg.
module tclp_back #(
  parameter int VALUE_BITS = tclp_pkg::ValueBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  tclp_pkg::phase_t      line_phase,
  input  logic                  line_word_ok,
  input  logic [2:0]            line_word,
  input  logic                  line_overflow,
  input  logic                  line_neg,
  input  logic [VALUE_BITS-1:0] line_acc,
  input  logic [31:0]           freq_min,
  input  logic [31:0]           freq_max,
  input  logic [7:0]            duty_max,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [2:0]            out_command,
  output logic [31:0]           out_value
);
  import tclp_pkg::*;

  typedef struct packed {
    phase_t                phase;
    logic                  word_ok;
    logic [2:0]            word;
    logic [VALUE_BITS-1:0] v;
  } line_t;

  line_t      q_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  line_t      inl, hd;
  logic       pop, o_vld_r;
  status_t    st;
  cmd_t       cm;
  logic [31:0] val;
  logic [VALUE_BITS-1:0] vn;

  // Value after sign and saturation.
  assign vn = line_overflow ? '1 : (line_neg ? VALUE_BITS'(-line_acc) : line_acc);
  assign inl = '{phase: line_phase, word_ok: line_word_ok, word: line_word, v: vn};

  assign full = (cnt_r == 2'd2);
  assign hd   = q_r[rp_r];
  assign pop  = (cnt_r != 2'd0) && (!o_vld_r || !out_stall);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= inl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Decide the result of the queue head.
  always_comb begin
    st = ST_SYNTAX; cm = OPC_NONE; val = '0;
    case (hd.phase)
      PH_LEAD: st = ST_OK;
      PH_WORD, PH_TRAIL: begin
        if (hd.word_ok && hd.word < 3'(KwFreq)) begin
          st = ST_OK; cm = kw_cmd(hd.word);
        end
      end
      PH_ZERO, PH_DIGITS: begin
        if (hd.word == 3'(KwFreq)) begin
          if (64'(hd.v) < 64'(freq_min) || 64'(hd.v) > 64'(freq_max)) st = ST_RANGE;
          else begin
            st = ST_OK; cm = OPC_FREQ; val = 32'(hd.v);
          end
        end else if (hd.word == 3'(KwDuty)) begin
          if (64'(hd.v) > 64'(duty_max)) st = ST_RANGE;
          else begin
            st = ST_OK; cm = OPC_DUTY; val = 32'(hd.v);
          end
        end
      end
      default: st = ST_SYNTAX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (pop) o_vld_r <= 1'b1;
    else if (!out_stall) o_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status <= st; out_command <= cm; out_value <= val;
    end
  end

  assign out_valid = o_vld_r;
endmodule

// File: sv/text_command_line_parser.sv
// Top level of the text command line parser; instantiates tclp_front and
// tclp_back and holds the configuration registers. Depends on tclp_pkg.
//
// One character beat is taken every clock cycle unless the line queue is full;
// a CR, LF or NUL beat ends the line, and its result passes through the line
// queue and then the result register, waiting while the result side is stalled.
// The scanner updates its line state for each character taken, and a two-entry
// queue plus the result register hold up to three results before the input stalls.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
module text_command_line_parser #(
  parameter int LINE_BUFFER = tclp_pkg::LineBufferDef,
  parameter int VALUE_BITS  = tclp_pkg::ValueBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_command,
  output logic [31:0] out_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tclp_pkg::*;

  logic [31:0] freq_min_r, freq_max_r;
  logic [7:0]  duty_max_r;
  logic        push, full, l_ok, l_ovf, l_neg;
  phase_t      l_ph;
  logic [2:0]  l_w;
  logic [VALUE_BITS-1:0] l_acc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_min_r <= 32'd1; freq_max_r <= 32'd40000000; duty_max_r <= 8'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgFreqMin: freq_min_r <= cfg_data;
        CfgFreqMax: freq_max_r <= cfg_data;
        CfgDutyMax: duty_max_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tclp_front #(.LINE_BUFFER(LINE_BUFFER), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_byte, .push, .full,
    .line_phase(l_ph), .line_word_ok(l_ok), .line_word(l_w),
    .line_overflow(l_ovf), .line_neg(l_neg), .line_acc(l_acc)
  );

  tclp_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst_n, .push, .full,
    .line_phase(l_ph), .line_word_ok(l_ok), .line_word(l_w),
    .line_overflow(l_ovf), .line_neg(l_neg), .line_acc(l_acc),
    .freq_min(freq_min_r), .freq_max(freq_max_r), .duty_max(duty_max_r),
    .out_valid, .out_stall, .out_status, .out_command, .out_value
  );

  // An error result never carries a command.
  a_err_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_command == OPC_NONE)
    else $error("error result carries a command");

  // Only frequency and duty results carry a value.
  a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command != OPC_FREQ && out_command != OPC_DUTY |-> out_value == '0)
    else $error("nonzero value without a value command");

  // No line end is pushed while the queue is full.
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue overrun");
endmodule

// File: sim/text_command_line_parser_tb.sv
// Testbench for the text command line parser: a line predictor, directed and
// random command lines, random idling on both sides. Depends on tclp_pkg.
module text_command_line_parser_tb;
  import tclp_pkg::*;

  localparam int LineKeep = 63;

  typedef struct packed {
    status_t   status;
    cmd_t      command;
    logic [31:0] value;
  } line_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [2:0]  out_command;
  logic [31:0] out_value;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  text_command_line_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_byte(in_char_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_command(out_command), .out_value(out_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of configuration and line state.
  logic [31:0] lim_freq_min, lim_freq_max;
  logic [7:0]  lim_duty_max;
  int          ln_count;
  phase_t      ln_phase;
  logic [7:0]  ln_cands;
  int          ln_pos;
  base_t       ln_base;
  bit          ln_neg, ln_ovf, ln_digit, ln_spaces;
  logic [32:0] ln_acc;

  line_result_t pending_results[$];
  int  error_count;
  int  hold_cycles;
  bit  allow_out_idle;
  bit  allow_in_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #120000000;
    $display("[text_command_line_parser] ERROR");
    $finish;
  end

  // Keyword tables, written locally.
  function automatic string kw_word(int k);
    case (k)
      0: return "STATUS";
      1: return "ON";
      2: return "START";
      3: return "OFF";
      4: return "STOP";
      5: return "HELP";
      6: return "FREQ";
      default: return "DUTY";
    endcase
  endfunction

  function automatic cmd_t kw_code(int k);
    case (k)
      0: return OPC_STATUS;
      1, 2: return OPC_ON;
      3, 4: return OPC_OFF;
      5: return OPC_HELP;
      6: return OPC_FREQ;
      default: return OPC_DUTY;
    endcase
  endfunction

  // One-character string holding a byte.
  function automatic string chr(logic [7:0] b);
    string t;
    t = " ";
    t[0] = b;
    return t;
  endfunction

  function automatic int digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic int finished_word();
    string s;
    for (int k = 0; k < KwCount; k++) begin
      s = kw_word(k);
      if (ln_cands[k] && s.len() == ln_pos) return k;
    end
    return -1;
  endfunction

  function automatic int first_cand();
    for (int k = 0; k < KwCount; k++)
      if (ln_cands[k]) return k;
    return -1;
  endfunction

  function automatic void clear_line();
    ln_count = 0; ln_phase = PH_LEAD; ln_cands = 8'hFF; ln_pos = 0;
    ln_base = BASE_DEC; ln_neg = 0; ln_acc = '0; ln_ovf = 0;
    ln_digit = 0; ln_spaces = 0;
  endfunction

  function automatic void start_digits(base_t b, int d);
    ln_base = b; ln_acc = 33'(d); ln_digit = 1; ln_phase = PH_DIGITS;
  endfunction

  // Advance the line state by one kept character.
  function automatic void scan_char(logic [7:0] c);
    int d, w, radix;
    logic [7:0] m;
    string s;
    d = digit_of(c);
    if (ln_phase == PH_LEAD) begin
      if (c == " ") return;
      if (c == "?") begin
        ln_cands = 8'h01; ln_phase = PH_TRAIL; return;
      end
      ln_phase = PH_WORD;
    end
    case (ln_phase)
      PH_WORD: begin
        if (c == " ") begin
          w = finished_word();
          if (w < 0) begin
            ln_phase = PH_BAD;
          end else begin
            ln_cands = 8'(1 << w);
            ln_phase = (w == KwFreq || w == KwDuty) ? PH_NUMWS : PH_TRAIL;
          end
        end else begin
          m = '0;
          for (int k = 0; k < KwCount; k++) begin
            s = kw_word(k);
            if (ln_cands[k] && s.len() > ln_pos && s[ln_pos] == c) m[k] = 1'b1;
          end
          if (m == 0) ln_phase = PH_BAD;
          else begin
            ln_cands = m; ln_pos++;
          end
        end
      end
      PH_TRAIL: if (c != " ") ln_phase = PH_BAD;
      PH_NUMWS, PH_SIGN: begin
        if (ln_phase == PH_NUMWS && (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C))
          return;
        if (ln_phase == PH_NUMWS && c == "+") begin
          ln_phase = PH_SIGN; return;
        end
        if (ln_phase == PH_NUMWS && c == "-") begin
          ln_neg = 1; ln_phase = PH_SIGN; return;
        end
        if (c == "0") begin
          ln_digit = 1; ln_phase = PH_ZERO;
        end else if (c >= "1" && c <= "9") start_digits(BASE_DEC, d);
        else ln_phase = PH_BAD;
      end
      PH_ZERO: begin
        if (c == "x" || c == "X") ln_phase = PH_X;
        else if (c >= "0" && c <= "7") start_digits(BASE_OCT, d);
        else if (c == " ") begin
          start_digits(BASE_OCT, 0); ln_spaces = 1;
        end else ln_phase = PH_BAD;
      end
      PH_X: begin
        if (d < 16) start_digits(BASE_HEX, d);
        else ln_phase = PH_BAD;
      end
      PH_DIGITS: begin
        radix = (ln_base == BASE_DEC) ? 10 : (ln_base == BASE_OCT ? 8 : 16);
        if (c == " ") ln_spaces = 1;
        else if (ln_spaces || d >= radix) ln_phase = PH_BAD;
        else if (!ln_ovf) begin
          if (ln_acc > (33'hFFFF_FFFF - 33'(d)) / 33'(radix)) ln_ovf = 1;
          else ln_acc = ln_acc * 33'(radix) + 33'(d);
        end
      end
      default: ln_phase = PH_BAD;
    endcase
  endfunction

  function automatic line_result_t close_line();
    line_result_t r;
    int w;
    logic [31:0] v;
    r.status = ST_SYNTAX; r.command = OPC_NONE; r.value = '0;
    if (ln_phase == PH_LEAD) r.status = ST_OK;
    else if (ln_phase == PH_WORD) begin
      w = finished_word();
      if (w >= 0 && w < KwFreq) begin
        r.status = ST_OK; r.command = kw_code(w);
      end
    end else if (ln_phase == PH_TRAIL) begin
      w = first_cand();
      if (w >= 0) begin
        r.status = ST_OK; r.command = kw_code(w);
      end
    end else if ((ln_phase == PH_ZERO || ln_phase == PH_DIGITS) && ln_digit) begin
      v = ln_ovf ? 32'hFFFF_FFFF : (ln_neg ? 32'(0 - ln_acc[31:0]) : ln_acc[31:0]);
      w = first_cand();
      if (w == KwFreq) begin
        if (v < lim_freq_min || v > lim_freq_max) r.status = ST_RANGE;
        else begin
          r.status = ST_OK; r.command = OPC_FREQ; r.value = v;
        end
      end else if (w == KwDuty) begin
        if (v > 32'(lim_duty_max)) r.status = ST_RANGE;
        else begin
          r.status = ST_OK; r.command = OPC_DUTY; r.value = v;
        end
      end
    end
    return r;
  endfunction

  function automatic void predict_char(logic [7:0] c);
    if (c == 8'h00 || c == 8'h0D || c == 8'h0A) begin
      pending_results.push_back(close_line());
      clear_line();
    end else if (ln_count < LineKeep) begin
      ln_count++;
      scan_char(c);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  function automatic int idle_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Send one character beat, with an optional random gap before it.
  task automatic send_char(logic [7:0] c);
    int gap;
    gap = allow_in_idle ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c);
  endtask

  task automatic send_line(string s, logic [7:0] term = 8'h0D);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(term);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgFreqMin: lim_freq_min = val;
      CfgFreqMax: lim_freq_max = val;
      default: lim_duty_max = val[7:0];
    endcase
    @(posedge clk);
  endtask

  // Result checker against the oldest expected line result.
  always @(posedge clk) begin
    line_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0)
        report_mismatch("unexpected beat", 32'(out_status), 32'd0);
      else begin
        e = pending_results.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", 32'(out_status), 32'(e.status));
        if (out_command !== e.command)
          report_mismatch("command", 32'(out_command), 32'(e.command));
        if (out_value !== e.value) report_mismatch("value", out_value, e.value);
      end
    end
  end

  // Receiver stall: random idling, or a long counted hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (allow_out_idle) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  function automatic logic [7:0] rand_line_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1, 2: return " ";
      3: return "x";
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic string rand_number();
    string s;
    string pre;
    string hexd;
    int n, j;
    s = "";
    hexd = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 5))
      0: pre = "0x";
      1: pre = "0X";
      2: pre = "0";
      3: pre = "-";
      4: pre = "+0x";
      default: pre = "";
    endcase
    if ($urandom_range(0, 5) == 0) s = {s, " "};
    if ($urandom_range(0, 7) == 0) s = {s, chr(8'h09)};
    s = {s, pre};
    n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (pre == "0x" || pre == "0X" || pre == "+0x") begin
        j = $urandom_range(0, 21);
        s = {s, hexd.substr(j, j)};
      end else if (pre == "0") s = {s, chr(8'("0" + $urandom_range(0, 7)))};
      else s = {s, chr(8'("0" + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  function automatic logic [7:0] rand_term();
    case ($urandom_range(0, 2))
      0: return 8'h00;
      1: return 8'h0A;
      default: return 8'h0D;
    endcase
  endfunction

  // Build one random command line; mostly well formed.
  function automatic string rand_line();
    string s, w;
    int pick;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, " "};
    pick = $urandom_range(0, 19);
    if (pick < 16) begin
      w = (pick < 10) ? (pick[0] ? "FREQ" : "DUTY") : kw_word($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) w = "?";
      if ($urandom_range(0, 15) == 0) w = w.substr(0, w.len() - 2);
      s = {s, w};
      if (w == "FREQ" || w == "DUTY") s = {s, " ", rand_number()};
      if ($urandom_range(0, 12) == 0) s = {s, chr(8'($urandom_range(32, 126)))};
    end else if (pick < 19) begin
      repeat ($urandom_range(1, 10)) s = {s, chr(rand_line_char())};
    end else begin
      repeat ($urandom_range(60, 70)) s = {s, "5"};
    end
    repeat ($urandom_range(0, 2)) s = {s, " "};
    for (int i = 0; i < s.len(); i++)
      if (s[i] == 8'h00 || s[i] == 8'h0D || s[i] == 8'h0A) s[i] = "y";
    return s;
  endfunction

  task automatic test_directed();
    string lng;
    send_line("");
    send_line("    ", 8'h0A);
    send_line("?");
    send_line(" STATUS  ", 8'h00);
    send_line("ON"); send_line("START"); send_line("OFF"); send_line("STOP");
    send_line("HELP"); send_line("STA"); send_line("FREQ"); send_line("HELP X");
    send_line("FREQ 1000"); send_line("FREQ 0x1F"); send_line("FREQ 0x");
    send_line("FREQ 017"); send_line("FREQ 019"); send_line("FREQ 0");
    send_line("DUTY 100"); send_line("DUTY 101"); send_line("DUTY -1");
    send_line("FREQ 99999999999"); send_line("DUTY  +5  "); send_line("DUTY 5 5");
    lng = "FREQ 1";
    repeat (70) lng = {lng, " "};
    lng = {lng, "Z", chr(8'hFF), chr(8'h80)};
    send_line(lng);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(CfgFreqMin, 32'h0);
    write_reg(CfgFreqMax, 32'hFFFF_FFFF);
    write_reg(CfgDutyMax, 32'hFF);
    send_line("FREQ 0"); send_line("FREQ -1"); send_line("DUTY 255");
    send_line("DUTY 0xFFFFFFFFF"); send_line("FREQ 4294967295");
    wait_drained();
    write_reg(CfgFreqMin, 32'hFFFF_FFFF);
    write_reg(CfgFreqMax, 32'h0);
    write_reg(CfgDutyMax, 32'h0);
    send_line("FREQ 0"); send_line("DUTY 0"); send_line("DUTY 1");
    wait_drained();
  endtask

  task automatic test_random_lines(int chars);
    int sent;
    string s;
    sent = 0;
    while (sent < chars) begin
      s = rand_line();
      send_line(s, rand_term());
      sent += s.len() + 1;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    allow_in_idle = 0;
    repeat (20) send_line("DUTY 7");
    allow_in_idle = 1;
    wait_drained();
  endtask

  task automatic test_random_config_phases();
    for (int p = 0; p < 4; p++) begin
      write_reg(CfgFreqMin, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 50));
      write_reg(CfgFreqMax, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(100, 70000));
      write_reg(CfgDutyMax, $urandom_range(0, 255));
      test_random_lines(150);
      wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_char_byte = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    error_count = 0; hold_cycles = 0; allow_out_idle = 0; allow_in_idle = 0;
    lim_freq_min = 32'd1; lim_freq_max = 32'd40000000; lim_duty_max = 8'd100;
    clear_line();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    allow_out_idle = 1; allow_in_idle = 1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    write_reg(CfgFreqMin, 32'd1);
    write_reg(CfgFreqMax, 32'd40000000);
    write_reg(CfgDutyMax, 32'd100);
    test_random_lines(200);
    wait_drained();
    test_random_config_phases();
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[text_command_line_parser] OK");
    end else begin
      $display("[text_command_line_parser] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/tclp_pkg.sv
sv/tclp_front.sv
sv/tclp_back.sv
sv/text_command_line_parser.sv
sim/text_command_line_parser_tb.sv
